// File: rtl/core/cia_pkg.sv
// Shared types and codes for the channel identifier allocator.
package cia_pkg;

    localparam int IdW      = 10;
    localparam int ProtoW   = 16;
    localparam int MaxId    = (1 << IdW) - 1;
    localparam int WordW    = 32;
    localparam int BitIdxW  = 5;
    localparam int WordIdxW = IdW - BitIdxW;
    localparam int NumWords = 1 << WordIdxW;

    localparam logic [1:0] ModeAlloc   = 2'd0;
    localparam logic [1:0] ModeRelease = 2'd1;
    localparam logic [1:0] ModeLookup  = 2'd2;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusNoneFree = 2'd1;
    localparam logic [1:0] StatusNotFound = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [IdW-1:0]    chan_id;
        logic [ProtoW-1:0] proto_word;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [IdW-1:0]    result_id;
        logic              in_use;
        logic [ProtoW-1:0] stored_proto;
    } rsp_t;

endpackage

// File: rtl/core/channel_id_allocator.sv
// Channel identifier allocator: used-mark and protocol-word memories with round-robin search.
// Sequence: release and lookup read the marks at the accepting edge and answer from S_CHECK;
// allocate visits the 32-bit mark words in turn, at most every word plus a closing revisit
// of the start word, through the one-word-per-cycle read port of the marks.
// Throughput: one request at a time; busy drops with the response strobe, so the next request
// is taken at the edge that ends it.
// Reset: a sweep clears the 32 mark words with busy high; the receiver cannot stall.
module channel_id_allocator #(
    parameter int FIRST_ID = 64,
    parameter int LAST_ID  = 1023
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  cia_pkg::req_t  req,
    output logic           done,
    output cia_pkg::rsp_t  rsp
);

    // Effective range of identifiers the store can hold.
    localparam int TopId    = (LAST_ID > cia_pkg::MaxId) ? cia_pkg::MaxId : LAST_ID;
    localparam int BottomId = (FIRST_ID > TopId) ? TopId : FIRST_ID;

    localparam logic [cia_pkg::IdW-1:0] TopIdV    = cia_pkg::IdW'(TopId);
    localparam logic [cia_pkg::IdW-1:0] BottomIdV = cia_pkg::IdW'(BottomId);
    localparam logic [cia_pkg::WordIdxW-1:0] TopWord =
        TopIdV[cia_pkg::IdW-1:cia_pkg::BitIdxW];
    localparam logic [cia_pkg::WordIdxW-1:0] BottomWord =
        BottomIdV[cia_pkg::IdW-1:cia_pkg::BitIdxW];

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

    // Lowest set bit of a mark word.
    function automatic logic [cia_pkg::BitIdxW-1:0] first_set(
        input logic [cia_pkg::WordW-1:0] v
    );
        logic [cia_pkg::BitIdxW-1:0] idx;
        idx = '0;
        for (int b = cia_pkg::WordW - 1; b >= 0; b--) begin
            if (v[b]) begin
                idx = cia_pkg::BitIdxW'(b);
            end
        end
        return idx;
    endfunction

    // Storage: marks packed 32 to a word, one protocol word per identifier.
    logic [cia_pkg::WordW-1:0]  used_mem  [cia_pkg::NumWords];
    logic [cia_pkg::ProtoW-1:0] proto_mem [1 << cia_pkg::IdW];

    state_t                        state_reg, state_next;
    logic [1:0]                    mode_reg, mode_next;
    logic [cia_pkg::IdW-1:0]       id_reg, id_next;
    logic [cia_pkg::ProtoW-1:0]    pw_reg, pw_next;
    logic [cia_pkg::WordIdxW-1:0]  word_reg, word_next;
    logic [cia_pkg::WordIdxW-1:0]  start_word_reg, start_word_next;
    logic [cia_pkg::BitIdxW-1:0]   start_bit_reg, start_bit_next;
    logic                          pass_reg, pass_next;
    logic [cia_pkg::IdW-1:0]       last_reg, last_next;
    logic [cia_pkg::WordIdxW-1:0]  clr_reg, clr_next;
    logic                          done_reg, done_next;
    cia_pkg::rsp_t                 rsp_reg, rsp_next;
    logic [cia_pkg::WordW-1:0]     used_rd_reg;
    logic [cia_pkg::ProtoW-1:0]    proto_rd_reg;

    // Memory port controls.
    logic [cia_pkg::WordIdxW-1:0]  used_raddr;
    logic                          used_we;
    logic [cia_pkg::WordIdxW-1:0]  used_waddr;
    logic [cia_pkg::WordW-1:0]     used_wdata;
    logic                          proto_re;
    logic                          proto_we;
    logic [cia_pkg::IdW-1:0]       proto_waddr;

    // Search helpers.
    logic [cia_pkg::IdW-1:0]       start_id;
    logic [cia_pkg::WordW-1:0]     range_mask;
    logic [cia_pkg::WordW-1:0]     pass_mask;
    logic [cia_pkg::WordW-1:0]     free_vec;
    logic [cia_pkg::BitIdxW-1:0]   free_bit;
    logic [cia_pkg::WordIdxW-1:0]  adv_word;
    logic                          mark_bit;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Round-robin start: one past the last identifier handed out, wrapping to the bottom.
    assign start_id = (last_reg >= TopIdV || last_reg < BottomIdV) ? BottomIdV
                                                                   : last_reg + 1'b1;

    // Identifiers of the current word that lie inside the range.
    always_comb
    begin
        for (int b = 0; b < cia_pkg::WordW; b++) begin
            range_mask[b] = ({word_reg, cia_pkg::BitIdxW'(b)} >= BottomIdV) &&
                            ({word_reg, cia_pkg::BitIdxW'(b)} <= TopIdV);
            if (pass_reg) begin
                // Closing visit of the start word: only what lies below the start.
                pass_mask[b] = (cia_pkg::BitIdxW'(b) < start_bit_reg);
            end else if (word_reg == start_word_reg) begin
                pass_mask[b] = (cia_pkg::BitIdxW'(b) >= start_bit_reg);
            end else begin
                pass_mask[b] = 1'b1;
            end
        end
    end

    assign free_vec = ~used_rd_reg & range_mask & pass_mask;
    assign free_bit = first_set(free_vec);
    assign adv_word = (word_reg == TopWord) ? BottomWord : word_reg + 1'b1;
    assign mark_bit = used_rd_reg[id_reg[cia_pkg::BitIdxW-1:0]];

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        pw_next         = pw_reg;
        word_next       = word_reg;
        start_word_next = start_word_reg;
        start_bit_next  = start_bit_reg;
        pass_next       = pass_reg;
        last_next       = last_reg;
        clr_next        = clr_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        used_raddr      = word_reg;
        used_we         = 1'b0;
        used_waddr      = word_reg;
        used_wdata      = used_rd_reg;
        proto_re        = 1'b0;
        proto_we        = 1'b0;
        proto_waddr     = {word_reg, free_bit};

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the mark memory, one word per cycle.
                used_we    = 1'b1;
                used_waddr = clr_reg;
                used_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == cia_pkg::WordIdxW'(cia_pkg::NumWords - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start) begin
                    mode_next = req.mode;
                    id_next   = req.chan_id;
                    pw_next   = req.proto_word;
                    if (req.mode == cia_pkg::ModeAlloc) begin
                        word_next       = start_id[cia_pkg::IdW-1:cia_pkg::BitIdxW];
                        start_word_next = start_id[cia_pkg::IdW-1:cia_pkg::BitIdxW];
                        start_bit_next  = start_id[cia_pkg::BitIdxW-1:0];
                        pass_next       = 1'b0;
                        used_raddr      = start_id[cia_pkg::IdW-1:cia_pkg::BitIdxW];
                        state_next      = S_SCAN;
                    end else begin
                        used_raddr = req.chan_id[cia_pkg::IdW-1:cia_pkg::BitIdxW];
                        proto_re   = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end

            S_SCAN:
            begin
                if (|free_vec) begin
                    // Claim the first free identifier in this word.
                    used_we    = 1'b1;
                    used_wdata = used_rd_reg | (cia_pkg::WordW'(1) << free_bit);
                    proto_we   = 1'b1;
                    last_next  = {word_reg, free_bit};
                    rsp_next.status       = cia_pkg::StatusOk;
                    rsp_next.result_id    = {word_reg, free_bit};
                    rsp_next.in_use       = 1'b1;
                    rsp_next.stored_proto = pw_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end else if (pass_reg) begin
                    rsp_next.status       = cia_pkg::StatusNoneFree;
                    rsp_next.result_id    = '0;
                    rsp_next.in_use       = 1'b0;
                    rsp_next.stored_proto = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    // Advance to the next word; read it this cycle.
                    word_next  = adv_word;
                    used_raddr = adv_word;
                    if (adv_word == start_word_reg) begin
                        pass_next = 1'b1;
                    end
                end
            end

            S_CHECK:
            begin
                rsp_next.result_id    = id_reg;
                rsp_next.in_use       = 1'b0;
                rsp_next.stored_proto = '0;
                rsp_next.status       = mark_bit ? cia_pkg::StatusOk
                                                 : cia_pkg::StatusNotFound;
                if (mode_reg == cia_pkg::ModeRelease) begin
                    if (mark_bit) begin
                        used_we    = 1'b1;
                        used_waddr = id_reg[cia_pkg::IdW-1:cia_pkg::BitIdxW];
                        used_wdata = used_rd_reg &
                                     ~(cia_pkg::WordW'(1) << id_reg[cia_pkg::BitIdxW-1:0]);
                    end
                end else if (mark_bit) begin
                    rsp_next.in_use       = 1'b1;
                    rsp_next.stored_proto = proto_rd_reg;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Mark memory: one read and one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (used_we) begin
            used_mem[used_waddr] <= used_wdata;
        end
        used_rd_reg <= used_mem[used_raddr];
    end

    // Protocol word memory.
    always_ff @(posedge clk)
    begin
        if (proto_we) begin
            proto_mem[proto_waddr] <= pw_reg;
        end
        if (proto_re) begin
            proto_rd_reg <= proto_mem[req.chan_id];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            last_reg  <= TopIdV;
            pass_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            last_reg  <= last_next;
            pass_reg  <= pass_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        pw_reg         <= pw_next;
        word_reg       <= word_next;
        start_word_reg <= start_word_next;
        start_bit_reg  <= start_bit_next;
        rsp_reg        <= rsp_next;
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response strobe while a request is in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_none_free_null: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == cia_pkg::StatusNoneFree) |-> (rsp.result_id == '0))
        else $error("none-free response carries an identifier");

    a_in_use_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.in_use) |-> (rsp.result_id >= BottomIdV && rsp.result_id <= TopIdV))
        else $error("in-use identifier outside the range");

    a_scan_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && pass_reg) |-> (word_reg == start_word_reg))
        else $error("closing pass left the start word");
`endif

endmodule

// File: bench/tb_channel_id_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the round-robin channel identifier allocator.
module tb_channel_id_allocator;

    // Range of identifiers handed out by the block under its default parameters
    localparam int FirstId   = 64;
    localparam int LastId    = 1023;
    localparam int TopId     = (LastId > cia_pkg::MaxId) ? cia_pkg::MaxId : LastId;
    localparam int BottomId  = (FirstId > TopId) ? TopId : FirstId;
    localparam int RangeSize = TopId - BottomId + 1;

    // The unused mode encoding; the block answers it as a lookup
    localparam logic [1:0] ModeSpare = 2'd3;

    // Wait well past the longest allocate before ending
    localparam int DrainCycles = 80;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    logic           busy;
    cia_pkg::req_t  req;
    logic           done;
    cia_pkg::rsp_t  rsp;

    // Shadow of the allocator state, advanced at each accepted request
    bit                         chan_used [0:cia_pkg::MaxId];
    logic [cia_pkg::ProtoW-1:0] chan_proto [0:cia_pkg::MaxId];
    int                         last_issued;
    int                         live_ids[$];

    // Responses still owed by the block, oldest first
    cia_pkg::rsp_t expected_rsps[$];
    cia_pkg::rsp_t want_rsp;

    int fail_count;
    int req_count;
    int rsp_count;
    int none_free_count;
    int not_found_count;

    channel_id_allocator #(
        .FIRST_ID(FirstId),
        .LAST_ID (LastId)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    always #10 clk = ~clk;

    // Drop an identifier from the list of currently allocated ones.
    function automatic void drop_live(int id);
        for (int i = 0; i < live_ids.size(); i++) begin
            if (live_ids[i] == id) begin
                live_ids.delete(i);
                break;
            end
        end
    endfunction

    // Apply one request to the shadow state and return the response it must produce.
    function automatic cia_pkg::rsp_t predict_channel_op(cia_pkg::req_t r);
        cia_pkg::rsp_t res;
        int            cand;
        int            id;
        res = '0;
        id  = r.chan_id;
        if (r.mode == cia_pkg::ModeAlloc) begin
            // Search round-robin from the one after the last handed out, wrapping
            // from the top back to the bottom; the last one itself is visited last.
            res.status = cia_pkg::StatusNoneFree;
            cand = last_issued;
            for (int n = 0; n < RangeSize; n++) begin
                cand = (cand >= TopId || cand < BottomId) ? BottomId : cand + 1;
                if (!chan_used[cand]) begin
                    chan_used[cand]  = 1'b1;
                    chan_proto[cand] = r.proto_word;
                    last_issued      = cand;
                    live_ids.push_back(cand);
                    res.status       = cia_pkg::StatusOk;
                    res.result_id    = cand[cia_pkg::IdW-1:0];
                    res.in_use       = 1'b1;
                    res.stored_proto = r.proto_word;
                    break;
                end
            end
            if (res.status == cia_pkg::StatusNoneFree)
                none_free_count++;
        end else if (r.mode == cia_pkg::ModeRelease) begin
            res.result_id = r.chan_id;
            if (chan_used[id]) begin
                chan_used[id] = 1'b0;
                drop_live(id);
                res.status = cia_pkg::StatusOk;
            end else begin
                res.status = cia_pkg::StatusNotFound;
                not_found_count++;
            end
        end else begin
            // Lookup, and the spare mode that behaves as one
            res.result_id = r.chan_id;
            if (chan_used[id]) begin
                res.status       = cia_pkg::StatusOk;
                res.in_use       = 1'b1;
                res.stored_proto = chan_proto[id];
            end else begin
                res.status = cia_pkg::StatusNotFound;
                not_found_count++;
            end
        end
        return res;
    endfunction

    function automatic cia_pkg::req_t make_request(logic [1:0] m, int id, int pw);
        cia_pkg::req_t r;
        r.mode       = m;
        r.chan_id    = id[cia_pkg::IdW-1:0];
        r.proto_word = pw[cia_pkg::ProtoW-1:0];
        return r;
    endfunction

    // Favor the extremes of the protocol word now and then.
    function automatic int pick_proto();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return 16'hFFFF;
        return $urandom_range(0, 16'hFFFF);
    endfunction

    function automatic int pick_live();
        return live_ids[$urandom_range(0, live_ids.size() - 1)];
    endfunction

    // Mostly well-formed traffic on live identifiers, with a share of noise.
    function automatic cia_pkg::req_t random_request();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return make_request(cia_pkg::ModeAlloc, $urandom_range(0, cia_pkg::MaxId),
                                pick_proto());
        if (sel < 70 && live_ids.size() != 0)
            return make_request(cia_pkg::ModeRelease, pick_live(), pick_proto());
        if (sel < 90 && live_ids.size() != 0)
            return make_request(($urandom_range(0, 4) == 0) ? ModeSpare : cia_pkg::ModeLookup,
                                pick_live(), pick_proto());
        return make_request(2'($urandom_range(0, 3)), $urandom_range(0, cia_pkg::MaxId),
                            pick_proto());
    endfunction

    // Present one request from a falling edge, hold it until a rising edge
    // sees busy low, predict its response, then drop start at the next falling edge.
    task automatic send_request(input cia_pkg::req_t r);
        @(negedge clk);
        req   <= r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        expected_rsps.push_back(predict_channel_op(r));
        req_count++;
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Compare every response strobe with the oldest outstanding prediction.
    always @(posedge clk) begin
        if (rst_n && done) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
                $error("unexpected response: status %0d id %0d", rsp.status, rsp.result_id);
                fail_count++;
            end else begin
                want_rsp = expected_rsps.pop_front();
                if (rsp.status !== want_rsp.status) begin
                    $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
                    fail_count++;
                end
                if (rsp.result_id !== want_rsp.result_id) begin
                    $error("result_id: expected %0d, got %0d",
                           want_rsp.result_id, rsp.result_id);
                    fail_count++;
                end
                if (rsp.in_use !== want_rsp.in_use) begin
                    $error("in_use: expected %0d, got %0d", want_rsp.in_use, rsp.in_use);
                    fail_count++;
                end
                if (rsp.stored_proto !== want_rsp.stored_proto) begin
                    $error("stored_proto: expected %h, got %h",
                           want_rsp.stored_proto, rsp.stored_proto);
                    fail_count++;
                end
            end
        end
    end

    // Edge identifiers, every mode, and the not-in-use and out-of-range answers.
    task automatic test_directed();
        send_request(make_request(cia_pkg::ModeLookup, BottomId, 0));
        send_request(make_request(cia_pkg::ModeRelease, BottomId, 0));
        // first allocate after reset must give the bottom of the range
        send_request(make_request(cia_pkg::ModeAlloc, cia_pkg::MaxId, 0));
        send_request(make_request(cia_pkg::ModeAlloc, 0, 16'hFFFF));
        send_request(make_request(cia_pkg::ModeLookup, BottomId, 16'hFFFF));
        send_request(make_request(cia_pkg::ModeLookup, BottomId + 1, 0));
        send_request(make_request(ModeSpare, BottomId + 1, 16'h5A5A));
        // null, top and below-range identifiers are never in use here
        send_request(make_request(cia_pkg::ModeLookup, 0, 0));
        send_request(make_request(cia_pkg::ModeLookup, TopId, 0));
        send_request(make_request(cia_pkg::ModeLookup, 5, 0));
        send_request(make_request(cia_pkg::ModeRelease, 0, 16'hFFFF));
        send_request(make_request(cia_pkg::ModeRelease, BottomId - 1, 0));
        send_request(make_request(cia_pkg::ModeRelease, cia_pkg::MaxId, 0));
        // release, release again, and check the slot is not reused next
        send_request(make_request(cia_pkg::ModeRelease, BottomId + 1, 0));
        send_request(make_request(cia_pkg::ModeRelease, BottomId + 1, 0));
        send_request(make_request(cia_pkg::ModeLookup, BottomId + 1, 0));
        send_request(make_request(cia_pkg::ModeAlloc, 16'h0, 16'h8001));
        send_request(make_request(ModeSpare, BottomId, 0));
        send_request(make_request(ModeSpare, cia_pkg::MaxId, 16'hFFFF));
        send_request(make_request(cia_pkg::ModeAlloc, 16'h2AA, 16'h7FFE));
    endtask

    // Random traffic in bursts of random length separated by random gaps.
    task automatic test_random(input int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst; i++)
                send_request(random_request());
            sent += burst;
            // leave some bursts back to back
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 12)) @(negedge clk);
            // hold off now and then until the block has answered everything
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
    endtask

    // Release the newest identifier and reallocate: the search must move past it,
    // then churn with releases scattered behind the search point.
    task automatic test_churn();
        int held;
        wait_drained();
        held = last_issued;
        send_request(make_request(cia_pkg::ModeRelease, held, 0));
        send_request(make_request(cia_pkg::ModeAlloc, 0, pick_proto()));
        send_request(make_request(cia_pkg::ModeLookup, held, 0));
        for (int i = 0; i < 80; i++) begin
            if (live_ids.size() != 0 && $urandom_range(0, 1) == 0)
                send_request(make_request(cia_pkg::ModeRelease, pick_live(), 0));
            send_request(make_request(cia_pkg::ModeAlloc, $urandom_range(0, cia_pkg::MaxId),
                                      pick_proto()));
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req             = '0;
        fail_count      = 0;
        req_count       = 0;
        rsp_count       = 0;
        none_free_count = 0;
        not_found_count = 0;
        for (int i = 0; i <= cia_pkg::MaxId; i++) begin
            chan_used[i]  = 1'b0;
            chan_proto[i] = '0;
        end
        last_issued = TopId;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // busy covers the clearing sweep, so the first request simply waits
        test_directed();
        wait_drained();
        test_random(400);
        wait_drained();
        test_churn();

        wait_drained();
        repeat (DrainCycles) @(posedge clk);

        $display("run covered %0d requests and %0d responses on ids %0d..%0d,",
                 req_count, rsp_count, BottomId, TopId);
        $display("%0d none-free and %0d not-in-use answers", none_free_count, not_found_count);
        if (fail_count == 0)
            $display("tb_channel_id_allocator passed");
        else
            $display("tb_channel_id_allocator failed");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("tb_channel_id_allocator failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/cia_pkg.sv
rtl/core/channel_id_allocator.sv
bench/tb_channel_id_allocator.sv
